[rtl/core/url_percent_decoder_unit_macros.svh]
// Assertion macros used by the URL percent decoder RTL.
`ifndef URL_PERCENT_DECODER_UNIT_MACROS_SVH
`define URL_PERCENT_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent in one cycle implies the consequent in the same cycle.
`define UPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define UPD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/upd_pkg.sv]
`timescale 1ns / 1ps

package upd_pkg;

	// Character codes used by the decoder.
	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChPlus    = 8'h2B;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChZero    = 8'h30;
	localparam logic [7:0] ChNine    = 8'h39;
	localparam logic [7:0] ChUpperA  = 8'h41;
	localparam logic [7:0] ChUpperZ  = 8'h5A;
	localparam logic [7:0] ChLowerA  = 8'h61;
	localparam logic [7:0] HexTen    = 8'd10;
	localparam logic [7:0] LetterOffset = ChLowerA - HexTen;

	// Position inside a percent escape.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} upd_phase_t;

	// One result item plus a flag telling whether the step produces it.
	typedef struct packed {
		logic       emit;
		logic [7:0] out_byte;
		logic       has_byte;
		logic       end_of_string;
	} upd_result_t;

	// Hex digit value with no validity check: letters fold to lower case first.
	function automatic logic [7:0] digit_value(input logic [7:0] c);
		logic [7:0] lc;
		lc = c;
		if (c >= ChUpperA && c <= ChUpperZ) begin
			lc = c | 8'h20;
		end
		if (c >= ChZero && c <= ChNine) begin
			return c - ChZero;
		end
		return lc - LetterOffset;
	endfunction

	// Ordinary byte mapping: a plus sign decodes to a space.
	function automatic logic [7:0] plain_byte(input logic [7:0] c);
		return (c == ChPlus) ? ChSpace : c;
	endfunction

endpackage

[rtl/core/upd_decode.sv]
`timescale 1ns / 1ps

module upd_decode (
	input  upd_pkg::upd_phase_t  phase,
	input  logic [3:0]           held,
	input  logic [7:0]           in_byte,
	input  logic                 last,
	output upd_pkg::upd_result_t res,
	output upd_pkg::upd_phase_t  next_phase,
	output logic [3:0]           next_held
);

	logic [7:0] dv;

	// Value of the current byte taken as a hex digit.
	assign dv = upd_pkg::digit_value(in_byte);

	// Escape sequencing and result formation for one item.
	always_comb begin
		res        = '0;
		next_phase = upd_pkg::PH_IDLE;
		next_held  = held;
		case (phase)
			upd_pkg::PH_HIGH: begin
				if (last) begin
					// The string ended inside the escape: drop the percent sign
					// and treat this byte as ordinary, dropping a second percent.
					res.emit          = 1'b1;
					res.end_of_string = 1'b1;
					if (in_byte != upd_pkg::ChPercent) begin
						res.has_byte = 1'b1;
						res.out_byte = upd_pkg::plain_byte(in_byte);
					end
				end else begin
					next_held  = dv[3:0];
					next_phase = upd_pkg::PH_LOW;
				end
			end
			upd_pkg::PH_LOW: begin
				res.emit          = 1'b1;
				res.has_byte      = 1'b1;
				res.out_byte      = {held, 4'b0000} | dv;
				res.end_of_string = last;
			end
			default: begin
				if (in_byte == upd_pkg::ChPercent) begin
					if (last) begin
						res.emit          = 1'b1;
						res.end_of_string = 1'b1;
					end else begin
						next_phase = upd_pkg::PH_HIGH;
					end
				end else begin
					res.emit          = 1'b1;
					res.has_byte      = 1'b1;
					res.out_byte      = upd_pkg::plain_byte(in_byte);
					res.end_of_string = last;
				end
			end
		endcase
	end

endmodule

[rtl/core/url_percent_decoder_unit.sv]
`timescale 1ns / 1ps
// URL percent decoder: takes one encoded byte per cycle, with the final byte of
// a string flagged by last, and gives at most one decoded item per input item.
// A plus sign becomes a space, a percent sign and the two following bytes
// become one byte, and the final byte always yields an item with end_of_string
// set (has_byte low when only a dropped percent sign remains). An item is
// accepted every cycle while the output side keeps up. An accepted item is
// decoded in the input register, and its result is loaded into the result
// register as the item advances; the result is then offered until it is taken.
// Items that close no byte (a percent sign or a high digit) only advance the
// escape state and never wait on the output side.

`include "url_percent_decoder_unit_macros.svh"

module url_percent_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       end_of_string
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	upd_pkg::upd_phase_t  phase_q;
	logic [3:0]           held_q;
	upd_pkg::upd_result_t res;
	upd_pkg::upd_phase_t  next_phase;
	logic [3:0]           next_held;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 has_byte_q;
	logic                 end_q;
	logic                 out_free;
	logic                 advance;

	// The result register is free when empty or being taken this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (out_free || !res.emit);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= last;
		end
	end

	upd_decode u_decode (
		.phase      (phase_q),
		.held       (held_q),
		.in_byte    (byte_s1),
		.last       (last_s1),
		.res        (res),
		.next_phase (next_phase),
		.next_held  (next_held)
	);

	// Escape state advances as each item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_IDLE;
			held_q  <= 4'h0;
		end else if (advance) begin
			phase_q <= next_phase;
			held_q  <= next_held;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			out_byte_q <= res.out_byte;
			has_byte_q <= res.has_byte;
			end_q      <= res.end_of_string;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign has_byte      = has_byte_q;
	assign end_of_string = end_q;

	// A stall toward the source only happens while an item is held.
	`UPD_ASSERT_NOW(a_stall_holds_item, clk, arst_n, in_stall, valid_s1)
	// The final byte of a string leaves the escape state idle.
	`UPD_ASSERT_NEXT(a_last_resets_phase, clk, arst_n, advance && last_s1,
		phase_q == upd_pkg::PH_IDLE)
	// The final byte of a string always yields an end-of-string item.
	`UPD_ASSERT_NEXT(a_last_gives_end, clk, arst_n, advance && last_s1,
		out_valid_q && end_q)

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	// One decoded item as it should leave the block.
	typedef struct packed {
		logic [7:0] ch;
		logic       has;
		logic       eos;
	} decoded_t;

	// One line of the directed stimulus table.
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       typed;
		logic [7:0] exp_ch;
		logic       exp_has;
		logic       exp_eos;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       end_of_string;

	decoded_t   decoded_q[$];
	dir_row_t   dir_rows[$];
	logic [7:0] str_q[$];

	// Shadow copy of the escape state.
	upd_pkg::upd_phase_t esc_phase = upd_pkg::PH_IDLE;
	logic [7:0] esc_high  = 8'h00;

	int mismatch_count = 0;
	int items_sent     = 0;
	int strings_sent   = 0;
	int results_seen   = 0;
	int escapes_done   = 0;
	int cut_short      = 0;
	bit quiet          = 1'b0;
	bit calm           = 1'b0;

	url_percent_decoder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.has_byte     (has_byte),
		.end_of_string(end_of_string)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Hex digit value with no validity check; letters fold to lower case.
	function automatic logic [7:0] hex_digit_value(input logic [7:0] c);
		logic [7:0] folded;
		if (c >= upd_pkg::ChZero && c <= upd_pkg::ChNine) begin
			return c - upd_pkg::ChZero;
		end
		folded = (c >= upd_pkg::ChUpperA && c <= upd_pkg::ChUpperZ) ? c + 8'h20 : c;
		return folded - upd_pkg::ChLowerA + upd_pkg::HexTen;
	endfunction

	// Advances the shadow escape state by one byte and tells whether a result follows.
	function automatic bit percent_decode_step(input logic [7:0] c, input logic fin,
			output decoded_t res);
		logic [7:0] plain;
		plain = (c == upd_pkg::ChPlus) ? upd_pkg::ChSpace : c;
		res = '0;
		case (esc_phase)
			upd_pkg::PH_HIGH: begin
				if (fin) begin
					// The string ended inside the escape, so the percent sign is lost.
					esc_phase = upd_pkg::PH_IDLE;
					cut_short++;
					res = (c == upd_pkg::ChPercent) ? decoded_t'{8'h00, 1'b0, 1'b1}
						: decoded_t'{plain, 1'b1, 1'b1};
					return 1'b1;
				end
				esc_high  = hex_digit_value(c);
				esc_phase = upd_pkg::PH_LOW;
				return 1'b0;
			end
			upd_pkg::PH_LOW: begin
				esc_phase = upd_pkg::PH_IDLE;
				escapes_done++;
				res = '{{esc_high[3:0], 4'h0} | hex_digit_value(c), 1'b1, fin};
				return 1'b1;
			end
			default: begin
				esc_phase = upd_pkg::PH_IDLE;
				if (c == upd_pkg::ChPercent) begin
					if (fin) begin
						res = '{8'h00, 1'b0, 1'b1};
						return 1'b1;
					end
					esc_phase = upd_pkg::PH_HIGH;
					return 1'b0;
				end
				res = '{plain, 1'b1, fin};
				return 1'b1;
			end
		endcase
	endfunction

	// Offers one item after an optional gap and records what it should produce.
	task automatic send_byte(input logic [7:0] c, input logic fin, input int gap,
			input bit typed, input decoded_t typed_res);
		decoded_t res;
		bit       gives;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= c;
		last     <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (fin) begin
			strings_sent++;
		end
		gives = percent_decode_step(c, fin, res);
		if (gives) begin
			decoded_q.push_back(typed ? typed_res : res);
		end
	endtask

	// Holds the input side back until every pending item has come out.
	task automatic drain_output();
		in_valid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
	endtask

	task automatic add_row(input logic [7:0] c, input logic fin, input logic typed,
			input logic [7:0] eb, input logic eh, input logic ee);
		dir_rows.push_back('{c, fin, typed, eb, eh, ee});
	endtask

	function automatic logic [7:0] rand_hex_char();
		int k;
		k = $urandom_range(0, 21);
		if (k < 10) begin
			return upd_pkg::ChZero + 8'(k);
		end else if (k < 16) begin
			return upd_pkg::ChLowerA + 8'(k - 10);
		end
		return upd_pkg::ChUpperA + 8'(k - 16);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(1, 255));
	endfunction

	// Builds one random string: mostly well-formed content with some noise.
	task automatic build_string();
		int         len;
		int         r;
		logic [7:0] c;
		str_q.delete();
		len = $urandom_range(1, 10);
		while (str_q.size() < len) begin
			r = $urandom_range(0, 9);
			if (r <= 3) begin
				c = 8'($urandom_range(32, 126));
				str_q.push_back((c == upd_pkg::ChPercent) ? upd_pkg::ChPlus : c);
			end else if (r == 4) begin
				str_q.push_back(upd_pkg::ChPlus);
			end else if (r <= 7) begin
				str_q.push_back(upd_pkg::ChPercent);
				str_q.push_back(rand_hex_char());
				str_q.push_back(rand_hex_char());
			end else if (r == 8) begin
				str_q.push_back(upd_pkg::ChPercent);
				str_q.push_back(rand_byte());
				str_q.push_back(rand_byte());
			end else begin
				str_q.push_back(rand_byte());
			end
		end
		// Sometimes the string stops in the middle of an escape.
		if ($urandom_range(0, 5) == 0) begin
			str_q.push_back(upd_pkg::ChPercent);
			r = $urandom_range(0, 4);
			if (r == 1) begin
				str_q.push_back(rand_hex_char());
			end else if (r == 2) begin
				str_q.push_back(upd_pkg::ChPercent);
			end else if (r == 3) begin
				str_q.push_back(upd_pkg::ChPlus);
			end else if (r == 4) begin
				str_q.push_back(rand_byte());
			end
		end
	endtask

	// Output side: random stall bursts, none once the run winds down.
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			n = $urandom_range(1, 17);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat (($urandom_range(0, 5) == 0) ? n * 8 : n) @(posedge clk);
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (decoded_q.size() == 0) begin
				report_mismatch($sformatf("unexpected item byte=%02h has=%b end=%b",
					out_byte, has_byte, end_of_string));
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.ch) begin
					report_mismatch($sformatf("out_byte %02h, wanted %02h", out_byte, want.ch));
				end
				if (has_byte !== want.has) begin
					report_mismatch($sformatf("has_byte %b, wanted %b", has_byte, want.has));
				end
				if (end_of_string !== want.eos) begin
					report_mismatch($sformatf("end_of_string %b, wanted %b",
						end_of_string, want.eos));
				end
			end
		end
	end

	// Main stimulus.
	initial begin
		int rand_items;
		int gap;
		bit paused;
		in_valid = 1'b0;
		in_byte  = 8'h01;
		last     = 1'b0;
		arst_n   = 1'b0;
		rand_items = 0;
		paused     = 1'b0;

		// Directed table: byte, last, typed, expected byte, has_byte, end_of_string.
		add_row(8'h01, 1'b0, 1'b1, 8'h01, 1'b1, 1'b0);
		add_row(8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1);
		add_row(upd_pkg::ChPlus, 1'b0, 1'b1, upd_pkg::ChSpace, 1'b1, 1'b0);
		add_row(upd_pkg::ChPercent, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row("4", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row("1", 1'b0, 1'b1, "A", 1'b1, 1'b0);
		add_row(upd_pkg::ChPercent, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row("F", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row("f", 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0);
		// Escape closed by the last byte of the string.
		add_row(upd_pkg::ChPercent, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row("0", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row("9", 1'b1, 1'b1, 8'h09, 1'b1, 1'b1);
		// A lone percent sign as the last byte.
		add_row(upd_pkg::ChPercent, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1);
		// String ends right after a percent sign: plus, percent and a plain letter follow.
		add_row(upd_pkg::ChPercent, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(upd_pkg::ChPlus, 1'b1, 1'b1, upd_pkg::ChSpace, 1'b1, 1'b1);
		add_row(upd_pkg::ChPercent, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(upd_pkg::ChPercent, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1);
		add_row(upd_pkg::ChPercent, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row("q", 1'b1, 1'b1, "q", 1'b1, 1'b1);
		// Non-hex digits give wrapped values.
		add_row(upd_pkg::ChPercent, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row("Z", 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 17) : 0;
			send_byte(dir_rows[i].ch, dir_rows[i].fin, gap, dir_rows[i].typed,
				'{dir_rows[i].exp_ch, dir_rows[i].exp_has, dir_rows[i].exp_eos});
		end
		drain_output();

		// Random strings.
		while (rand_items < 1300) begin
			build_string();
			if ($urandom_range(0, 4) == 0) begin
				calm = ~calm;
			end
			if (!paused && rand_items >= 600) begin
				drain_output();
				paused = 1'b1;
			end
			quiet = (rand_items >= 1150);
			foreach (str_q[i]) begin
				gap = (quiet || calm || $urandom_range(0, 3) != 0) ? 0
					: $urandom_range(1, 17);
				send_byte(str_q[i], i == str_q.size() - 1, gap, 1'b0, '0);
				rand_items++;
			end
		end
		in_valid <= 1'b0;

		// Let the pipeline empty out.
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d strings, %0d items and %0d results, including %0d decoded escapes",
			strings_sent, items_sent, results_seen, escapes_done);
		$display("and %0d strings cut short inside an escape.", cut_short);
		if (mismatch_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("Timeout with %0d items still pending.", decoded_q.size());
		$display("tb_top failed");
		$finish;
	end

endmodule

[url_percent_decoder_unit.f]
+incdir+rtl/core
rtl/core/upd_pkg.sv
rtl/core/upd_decode.sv
rtl/core/url_percent_decoder_unit.sv
sim/tb_top.sv
